>>> hw/rtl/rtd_adc_to_temperature_defines.svh
// assertion macros for the rtd converter block
`ifndef RTD_ADC_TO_TEMPERATURE_DEFINES_SVH
`define RTD_ADC_TO_TEMPERATURE_DEFINES_SVH

`ifndef SYNTHESIS
// condition holds in the same cycle as the trigger
`define RTD_ASSERT_SAME(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("rtd assertion failed");
// condition holds in the cycle after the trigger
`define RTD_ASSERT_NEXT(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("rtd assertion failed");
`else
`define RTD_ASSERT_SAME(label, clk, rst, trig, cond)
`define RTD_ASSERT_NEXT(label, clk, rst, trig, cond)
`endif

`endif

>>> hw/rtl/rtd_pkg.sv
// types, constants and the resistance table for the rtd converter block
`timescale 1ns / 1ps

package rtd_pkg;

  localparam int CODE_W  = 16;
  localparam int TEMP_W  = 13;
  localparam int RES_W   = 15;
  localparam int IDX_W   = 5;
  localparam int DVD_W   = 25;
  localparam int DSR_W   = 16;
  localparam int CNT_W   = 5;
  localparam int QUO1_W  = 11;
  localparam int QUO2_W  = 7;

  localparam logic [CODE_W-1:0] ADC_ZERO  = 16'h8000;
  localparam logic [CODE_W-1:0] ADC_LIMIT = 16'hC000;
  localparam logic [16:0]       ADC_SPAN  = 17'h10000;
  localparam logic [DVD_W-1:0]  RREF_OHMS = 25'd2000;
  localparam logic [IDX_W-1:0]  IDX_LAST  = 5'd30;

  localparam logic signed [TEMP_W-1:0] T_FIRST = -13'sd500;
  localparam logic [11:0]              T_STEP  = 12'd100;

  localparam logic [RES_W-1:0] RES_TABLE [0:31] = '{
    15'd8031,  15'd8427,  15'd8822,  15'd9216,  15'd9609,  15'd10000, 15'd10390, 15'd10779,
    15'd11167, 15'd11554, 15'd11940, 15'd12324, 15'd12708, 15'd13090, 15'd13471, 15'd13851,
    15'd14229, 15'd14607, 15'd14983, 15'd15358, 15'd15733, 15'd16105, 15'd16477, 15'd16848,
    15'd17217, 15'd17586, 15'd17953, 15'd18319, 15'd18684, 15'd19047, 15'd19410, 15'd19771
  };

  function automatic logic [RES_W-1:0] res_at(input logic [IDX_W-1:0] i);
    return RES_TABLE[i];
  endfunction

  typedef enum logic {
    DIV_RES,
    DIV_INTERP
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    logic     scale;
    logic     idx_clear;
    logic     idx_inc;
  } rtd_cmd_t;

  typedef struct packed {
    logic code_ok;
    logic r_below;
    logic hit;
    logic idx_last;
    logic div_busy;
  } rtd_status_t;

endpackage

>>> hw/rtl/rtd_if.sv
// valid/ready channel interfaces for converter words and temperatures
`timescale 1ns / 1ps

interface rtd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] adc_code;

  modport source (output valid, output adc_code, input ready);
  modport sink (input valid, input adc_code, output ready);
endinterface

interface rtd_out_if;
  logic               valid;
  logic               ready;
  logic signed [12:0] temp_decicelsius;
  logic               temp_valid;

  modport source (output valid, output temp_decicelsius, output temp_valid, input ready);
  modport sink (input valid, input temp_decicelsius, input temp_valid, output ready);
endinterface

>>> hw/rtl/rtd_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module rtd_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [rtd_pkg::DVD_W-1:0] dividend,
  input  logic [rtd_pkg::DSR_W-1:0] divisor,
  output logic                      busy,
  output logic [rtd_pkg::DVD_W-1:0] quotient
);
  import rtd_pkg::*;

  logic [DVD_W-1:0] acc;
  logic [DSR_W:0]   rem;
  logic [DSR_W-1:0] dsr;
  logic [CNT_W-1:0] count;
  logic [DSR_W:0]   rem_sh;
  logic             fits;

  assign rem_sh   = {rem[DSR_W-1:0], acc[DVD_W-1]};
  assign fits     = rem_sh >= {1'b0, dsr};
  assign busy     = count != '0;
  assign quotient = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= CNT_W'(DVD_W);
    end else if (busy) begin
      count <= count - 1'b1;
    end
  end

  // dividend shifts out the top while quotient bits enter the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      acc <= {acc[DVD_W-2:0], fits};
      rem <= fits ? rem_sh - {1'b0, dsr} : rem_sh;
    end
  end

endmodule

>>> hw/rtl/rtd_datapath.sv
// resistance, table scan and interpolation datapath
`timescale 1ns / 1ps

module rtd_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  rtd_pkg::rtd_cmd_t                 cmd,
  input  logic [rtd_pkg::CODE_W-1:0]        adc_code,
  output rtd_pkg::rtd_status_t              status,
  output logic signed [rtd_pkg::TEMP_W-1:0] temp
);
  import rtd_pkg::*;

  logic [CODE_W-1:0] code;
  logic [RES_W-1:0]  r;
  logic [IDX_W-1:0]  idx;

  logic [DVD_W-1:0]  dvd;
  logic [DSR_W-1:0]  dsr;
  logic              div_busy;
  logic [DVD_W-1:0]  quo;
  logic [RES_W-1:0]  lo;
  logic [RES_W-1:0]  hi;
  logic [RES_W-1:0]  offs;
  logic [11:0]       base;

  assign lo   = res_at(idx);
  assign hi   = res_at(IDX_W'(idx + 1'b1));
  assign offs = r - lo;

  always_comb begin
    case (cmd.div_sel)
      DIV_RES: begin
        dvd = DVD_W'(code[CODE_W-2:0]) * RREF_OHMS;
        dsr = DSR_W'(ADC_SPAN - {1'b0, code});
      end
      DIV_INTERP: begin
        dvd = DVD_W'(offs) * DVD_W'(T_STEP);
        dsr = DSR_W'(hi - lo);
      end
      default: begin
        dvd = '0;
        dsr = '0;
      end
    endcase
  end

  rtd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dsr),
    .busy     (div_busy),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      code <= adc_code;
    end
    if (cmd.scale) begin
      r <= RES_W'({4'b0, quo[QUO1_W-1:0]} * 15'd10);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.idx_clear) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end
  end

  assign status.code_ok  = (code >= ADC_ZERO) && (code <= ADC_LIMIT);
  assign status.r_below  = r < res_at('0);
  assign status.hit      = r < hi;
  assign status.idx_last = idx == IDX_LAST;
  assign status.div_busy = div_busy;

  assign base = 12'(idx) * T_STEP;
  assign temp = T_FIRST + $signed({1'b0, base}) + $signed({6'b0, quo[QUO2_W-1:0]});

endmodule

>>> hw/rtl/rtd_ctrl.sv
// sequencer for range check, two divisions and the table scan
`timescale 1ns / 1ps

module rtd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rtd_pkg::rtd_status_t status,
  input  logic                 out_free,
  output rtd_pkg::rtd_cmd_t    cmd,
  output logic                 res_write,
  output logic                 res_ok
);
  import rtd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DIV1,
    S_WAIT1,
    S_SCALE,
    S_SEARCH,
    S_DIV2,
    S_WAIT2,
    S_FINISH
  } state_t;

  state_t state;

  assign in_ready  = state == S_IDLE;
  assign res_write = (state == S_FINISH) && out_free;

  always_comb begin
    cmd           = '0;
    cmd.div_sel   = DIV_RES;
    cmd.load      = in_ready && in_valid;
    case (state)
      S_DIV1: begin
        cmd.div_start = 1'b1;
      end
      S_SCALE: begin
        cmd.scale     = 1'b1;
        cmd.idx_clear = 1'b1;
      end
      S_SEARCH: begin
        cmd.idx_inc = !status.r_below && !status.hit && !status.idx_last;
      end
      S_DIV2: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_INTERP;
      end
      S_WAIT2: begin
        cmd.div_sel = DIV_INTERP;
      end
      default: begin
        cmd.div_sel = DIV_RES;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      res_ok <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (status.code_ok) begin
            state <= S_DIV1;
          end else begin
            res_ok <= 1'b0;
            state  <= S_FINISH;
          end
        end
        S_DIV1: begin
          state <= S_WAIT1;
        end
        S_WAIT1: begin
          if (!status.div_busy) begin
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          state <= S_SEARCH;
        end
        S_SEARCH: begin
          if (status.r_below) begin
            res_ok <= 1'b0;
            state  <= S_FINISH;
          end else if (status.hit) begin
            res_ok <= 1'b1;
            state  <= S_DIV2;
          end else if (status.idx_last) begin
            // at or above the last table point
            res_ok <= 1'b0;
            state  <= S_FINISH;
          end
        end
        S_DIV2: begin
          state <= S_WAIT2;
        end
        S_WAIT2: begin
          if (!status.div_busy) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/rtd_adc_to_temperature.sv
// PT1000 converter word to temperature, top level
// Takes one 16-bit offset-binary converter word per transaction and returns
// one temperature in tenths of a degree Celsius with a valid flag; codes
// outside 0x8000..0xC000, and resistances outside the table, give valid 0 and
// temperature 0. One item at a time: a word that lands in the table goes
// through two passes of the shared 25-bit restoring divider (sensor
// resistance, then the interpolation fraction, each with a wait for the
// divider to finish) and a linear scan of up to 31 table segments, one per
// cycle, between them; a word whose resistance falls below or above the
// table ends after the first division and the scan, and a code outside
// 0x8000..0xC000 ends after the range check. The result shows in the same
// cycle as the next word can be taken. A finished result waits in the
// output register while the next word is taken.
`timescale 1ns / 1ps
`include "rtd_adc_to_temperature_defines.svh"

module rtd_adc_to_temperature (
  input  logic             clk,
  input  logic             rst,
  rtd_in_if.sink           sample,
  rtd_out_if.source        result
);
  import rtd_pkg::*;

  rtd_cmd_t                 cmd;
  rtd_status_t              status;
  logic                     out_free;
  logic                     res_write;
  logic                     res_ok;
  logic signed [TEMP_W-1:0] temp;
  logic                     out_valid;
  logic signed [TEMP_W-1:0] out_temp;
  logic                     out_ok;

  assign out_free = !out_valid || result.ready;

  rtd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .status    (status),
    .out_free  (out_free),
    .cmd       (cmd),
    .res_write (res_write),
    .res_ok    (res_ok)
  );

  rtd_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .adc_code (sample.adc_code),
    .status   (status),
    .temp     (temp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_write) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_write) begin
      out_temp <= res_ok ? temp : '0;
      out_ok   <= res_ok;
    end
  end

  assign result.valid            = out_valid;
  assign result.temp_decicelsius = out_temp;
  assign result.temp_valid       = out_ok;

  `RTD_ASSERT_NEXT(a_busy_after_accept, clk, rst, sample.valid && sample.ready, !sample.ready)
  `RTD_ASSERT_SAME(a_invalid_is_zero, clk, rst, result.valid && !result.temp_valid,
                   result.temp_decicelsius == '0)
  `RTD_ASSERT_SAME(a_temp_in_range, clk, rst, result.valid && result.temp_valid,
                   result.temp_decicelsius >= -13'sd500 && result.temp_decicelsius <= 13'sd2599)
  `RTD_ASSERT_NEXT(a_write_shows, clk, rst, res_write, result.valid)

endmodule
